[sv/mrps_pkg.sv]
// Package with the types, constants and helper functions of the meter register poll sequencer.
package mrps_pkg;

  // Number of meter fields read in one round.
  localparam int unsigned FieldCount = 6;
  localparam int unsigned FieldIdxW  = $clog2(FieldCount + 1);

  // Widths of the configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Saturation limits of the elapsed-time counters.
  localparam logic [15:0] SinceReqMax = 16'hFFFF;
  localparam logic [7:0]  SinceRepMax = 8'hFF;

  // Byte count of a well-formed single-value reply.
  localparam logic [7:0] GoodByteCount = 8'd4;

  // Biased exponent of 1.0 in single precision.
  localparam logic [7:0] ExpOne = 8'd127;
  localparam logic [7:0] ExpMax = 8'hFF;

  // Register reset values.
  localparam logic [15:0] IntervalReset = 16'd5000;
  localparam logic [15:0] TimeoutReset  = 16'd5000;
  localparam logic [7:0]  GapReset      = 8'd10;
  localparam logic [10:0] LimitReset    = 11'd1440;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_INTERVAL = 2'd0,
    CFG_TIMEOUT  = 2'd1,
    CFG_GAP      = 2'd2,
    CFG_LIMIT    = 2'd3
  } cfg_idx_e;

  // Sequencer phases, one-hot.
  typedef enum logic [3:0] {
    PH_RESTART = 4'b0001,
    PH_GAP     = 4'b0010,
    PH_SEND    = 4'b0100,
    PH_WAIT    = 4'b1000
  } phase_e;

  // Input item: one millisecond tick with an optional response.
  typedef struct packed {
    logic        response_valid;
    logic [7:0]  response_byte_count;
    logic [31:0] response_word;
  } in_t;

  // Result item of one tick.
  typedef struct packed {
    logic        send_request;
    logic [15:0] request_register;
    logic        value_valid;
    logic [2:0]  value_field;
    logic [31:0] value_word;
    logic        reset_request;
    logic        round_idle;
  } out_t;

  // Configuration register contents.
  typedef struct packed {
    logic [15:0] request_interval_ms;
    logic [15:0] response_timeout_ms;
    logic [7:0]  inter_request_gap_ms;
    logic [10:0] failure_limit;
  } cfg_t;

  // Sequencer state carried from tick to tick.
  typedef struct packed {
    phase_e                 phase;
    logic [FieldIdxW-1:0]   field_index;
    logic [15:0]            since_request_ms;
    logic [7:0]             since_reply_ms;
    logic [10:0]            failure_count;
    logic [31:0]            voltage_word;
  } state_t;

  // Register address of each field; unused slots read as address zero.
  function automatic logic [15:0] field_addr(input logic [FieldIdxW-1:0] idx);
    logic [15:0] addr;
    unique case (idx)
      3'd0:    addr = 16'h0000;
      3'd1:    addr = 16'h0008;
      3'd2:    addr = 16'h0012;
      3'd3:    addr = 16'h002A;
      3'd4:    addr = 16'h0036;
      3'd5:    addr = 16'h0100;
      default: addr = 16'h0000;
    endcase
    return addr;
  endfunction

  // True when a single-precision pattern is below 1.0; a NaN is not.
  function automatic logic below_one(input logic [31:0] w);
    logic is_nan;
    is_nan = (w[30:23] == ExpMax) && (w[22:0] != 23'd0);
    return !is_nan && (w[31] || (w[30:23] < ExpOne));
  endfunction

endpackage

[sv/mrps_cfg_regs.sv]
// Configuration register bank of the meter register poll sequencer.
module mrps_cfg_regs import mrps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  // Write the addressed register; each keeps only its own width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.request_interval_ms  <= IntervalReset;
      cfg_q.response_timeout_ms  <= TimeoutReset;
      cfg_q.inter_request_gap_ms <= GapReset;
      cfg_q.failure_limit        <= LimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_INTERVAL: cfg_q.request_interval_ms  <= cfg_wdata_i;
        CFG_TIMEOUT:  cfg_q.response_timeout_ms  <= cfg_wdata_i;
        CFG_GAP:      cfg_q.inter_request_gap_ms <= cfg_wdata_i[7:0];
        CFG_LIMIT:    cfg_q.failure_limit        <= cfg_wdata_i[10:0];
        default:      cfg_q <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/mrps_step.sv]
// Next-state and result logic for one millisecond tick of the poll sequencer.
module mrps_step import mrps_pkg::*; (
  input  cfg_t   cfg_i,
  input  state_t state_i,
  input  in_t    item_i,
  output state_t state_o,
  output out_t   result_o
);

  logic [15:0] since_req_inc;
  logic [7:0]  since_rep_inc;
  logic        fail_inc;
  logic        fail_clr;
  logic [31:0] value_word;
  state_t      nxt;
  out_t        res;

  // Both elapsed counters advance first, saturating.
  assign since_req_inc = (state_i.since_request_ms == SinceReqMax) ?
                         state_i.since_request_ms : state_i.since_request_ms + 16'd1;
  assign since_rep_inc = (state_i.since_reply_ms == SinceRepMax) ?
                         state_i.since_reply_ms : state_i.since_reply_ms + 8'd1;

  assign value_word = (item_i.response_byte_count == GoodByteCount) ?
                      item_i.response_word : 32'd0;

  // One action per tick, chosen by the phase.
  always_comb begin
    nxt                  = state_i;
    nxt.since_request_ms = since_req_inc;
    nxt.since_reply_ms   = since_rep_inc;
    res                  = '0;
    fail_inc             = 1'b0;
    fail_clr             = 1'b0;
    unique case (state_i.phase)
      PH_RESTART: begin
        nxt.field_index      = FieldIdxW'(FieldCount);
        nxt.since_request_ms = 16'd0;
        nxt.phase            = PH_SEND;
      end
      PH_GAP: begin
        if (since_rep_inc > cfg_i.inter_request_gap_ms) begin
          nxt.phase = PH_SEND;
        end
      end
      PH_SEND: begin
        if (state_i.field_index >= FieldIdxW'(FieldCount)) begin
          // Round complete: start a new one once the interval has passed.
          if (since_req_inc >= cfg_i.request_interval_ms) begin
            nxt.field_index = '0;
            fail_inc        = below_one(state_i.voltage_word);
            fail_clr        = !below_one(state_i.voltage_word);
          end
        end else begin
          res.send_request     = 1'b1;
          res.request_register = field_addr(state_i.field_index);
          nxt.since_request_ms = 16'd0;
          nxt.phase            = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (item_i.response_valid) begin
          res.value_valid = 1'b1;
          res.value_field = 3'(state_i.field_index);
          res.value_word  = value_word;
          if (state_i.field_index == '0) begin
            nxt.voltage_word = value_word;
          end
          if (state_i.field_index < FieldIdxW'(FieldCount)) begin
            nxt.field_index = state_i.field_index + 1'b1;
          end
          nxt.since_reply_ms = 8'd0;
          nxt.phase          = PH_GAP;
        end
        // A late reply still delivers its value, but the timeout wins.
        if (since_req_inc > cfg_i.response_timeout_ms) begin
          fail_inc  = 1'b1;
          nxt.phase = PH_RESTART;
        end
      end
      default: begin
        nxt.phase = PH_SEND;
      end
    endcase

    // Failure counter saturates at the limit and clears on a good round.
    if (fail_clr) begin
      nxt.failure_count = '0;
    end else if (fail_inc && (state_i.failure_count < cfg_i.failure_limit)) begin
      nxt.failure_count = state_i.failure_count + 11'd1;
    end

    res.reset_request = (nxt.failure_count >= cfg_i.failure_limit);
    res.round_idle    = (nxt.field_index >= FieldIdxW'(FieldCount)) &&
                        (nxt.phase == PH_SEND);
  end

  assign state_o  = nxt;
  assign result_o = res;

endmodule

[sv/meter_register_poll_sequencer_core.sv]
// Top level of the meter register poll sequencer: input register, step logic, result register.
// Path: a transfer on the input channel passes the input register, then the result
// register, on its way to the output.
// Throughput: one item per cycle while the output is not stalled; state updates once per item.
// Reset: rst_ni clears both stage valids, resets sequencer state, restores register defaults.
module meter_register_poll_sequencer_core import mrps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t   cfg;
  logic   in_valid_q;
  in_t    in_q;
  logic   out_valid_q;
  out_t   out_q;
  state_t state_q;
  state_t state_d;
  out_t   result_d;
  logic   advance;

  mrps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mrps_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (in_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // The held item moves on when the result register is empty or being drained.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Sequencer state updates once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase            <= PH_SEND;
      state_q.field_index      <= '0;
      state_q.since_request_ms <= '0;
      state_q.since_reply_ms   <= '0;
      state_q.failure_count    <= '0;
      state_q.voltage_word     <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/mrps_checker.sv]
// Port-level checker for the meter register poll sequencer, with its bind statement.
module mrps_checker import mrps_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // An offered tick stays offered with the same payload until its transfer.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input changed while stalled");

  // A stalled result stays offered with the same payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // A tick may send a request or deliver a value, never both.
  a_send_xor_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.send_request && out_data_o.value_valid))
    else $error("request and value in the same result");

  // Waiting for the next round excludes sending a request in that tick.
  a_idle_no_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.round_idle |-> !out_data_o.send_request)
    else $error("request sent while round idle");

  // Fields without their valid flag read as zero.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.send_request || (out_data_o.request_register == 16'd0)) &&
      (out_data_o.value_valid ||
       ((out_data_o.value_field == 3'd0) && (out_data_o.value_word == 32'd0))))
    else $error("unqualified result field is not zero");

endmodule

bind meter_register_poll_sequencer_core mrps_checker u_mrps_checker (.*);
